// File: rtl/trt_pkg.sv
// Shared types and constants of the transaction ID remap table.
// Used by the channel interfaces, the entry store and the top level.
`default_nettype none

package trt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);

   localparam int ID_W    = 16;
   localparam int LEN_W   = 16;
   localparam int RETX_W  = 3;
   localparam int TMO_W   = 4;
   localparam int SLOT_W  = 3;
   localparam int ACT_W   = 7;
   localparam int CNT_W   = 32;
   localparam int CSR_A_W = 2;
   localparam int CSR_D_W = 16;

   localparam logic [RETX_W-1:0] RETX_RESET   = 3'd1;
   localparam logic [TMO_W-1:0]  TMO_RESET    = 4'd5;
   localparam logic [LEN_W-1:0]  MINLEN_RESET = 16'd12;
   localparam logic [TMO_W-1:0]  WHEEL_MIN    = 4'd2;
   localparam logic [TMO_W-1:0]  WHEEL_MAX    = 4'd8;

   localparam logic [CSR_A_W-1:0] CSR_RETX   = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_TMO    = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_MINLEN = 2'd2;

   typedef enum logic [1:0] {
      OP_QUERY = 2'd0,
      OP_REPLY = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_FORWARDED = 3'd0,
      KIND_EVICTED   = 3'd1,
      KIND_MATCHED   = 3'd2,
      KIND_ORPHANED  = 3'd3,
      KIND_SHORT     = 3'd4,
      KIND_RESEND    = 3'd5,
      KIND_EXPIRED   = 3'd6,
      KIND_IDLE      = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_FWD,
      ST_SCAN,
      ST_SCAN_END
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]   relay_id;
      logic [ID_W-1:0]   orig_id;
      logic [ID_W-1:0]   client_tag;
      logic [RETX_W-1:0] retries;
      logic [SLOT_W-1:0] slot;
   } entry_type;

   // Store access for one cycle: one read, one write of data and/or valid bit.
   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic             vld_en;
      logic [IDX_W-1:0] wr_addr;
      logic             wr_valid;
      entry_type        wr_data;
   } tbl_ctl_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } tbl_rd_type;

   typedef struct packed {
      kind_type         kind;
      logic [ID_W-1:0]  relay_id;
      logic [ID_W-1:0]  orig_id;
      logic [ID_W-1:0]  client_tag;
      logic [ACT_W-1:0] active_total;
      logic [CNT_W-1:0] expired_total;
      logic [CNT_W-1:0] late_total;
      logic [CNT_W-1:0] collision_total;
      logic             last;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/trt_ifs.sv
// Valid/ready channel interfaces of the remap table: requests, results, CSR writes.
// Most widths come from trt_pkg; operation and kind are fixed at 2 and 3 bits.
`default_nettype none

interface trt_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    operation;
   logic [trt_pkg::ID_W-1:0]      txn_id;
   logic [trt_pkg::ID_W-1:0]      client_tag;
   logic [trt_pkg::LEN_W-1:0]     msg_length;

   modport source (output valid, operation, txn_id, client_tag, msg_length, input ready);
   modport sink   (input valid, operation, txn_id, client_tag, msg_length, output ready);
endinterface

interface trt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [2:0]                    kind;
   logic [trt_pkg::ID_W-1:0]      relay_id;
   logic [trt_pkg::ID_W-1:0]      orig_id;
   logic [trt_pkg::ID_W-1:0]      client_tag_out;
   logic [trt_pkg::ACT_W-1:0]     active_total;
   logic [trt_pkg::CNT_W-1:0]     expired_total;
   logic [trt_pkg::CNT_W-1:0]     late_total;
   logic [trt_pkg::CNT_W-1:0]     collision_total;
   logic                          last;

   modport source (output valid, kind, relay_id, orig_id, client_tag_out, active_total,
                   expired_total, late_total, collision_total, last, input ready);
   modport sink   (input valid, kind, relay_id, orig_id, client_tag_out, active_total,
                   expired_total, late_total, collision_total, last, output ready);
endinterface

interface trt_csr_if;
   logic                          valid;
   logic                          ready;
   logic [trt_pkg::CSR_A_W-1:0]   index;
   logic [trt_pkg::CSR_D_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/transaction_id_remap_table.sv
// Top level of the transaction ID remap table: control sequencer, counters, output register.
// Depends on trt_pkg, the trt_*_if interfaces and trt_table.
//
// Use: req_ch carries one item per query, reply or tick; rsp_ch returns the
// results of that item in order, the final one flagged by last. csr_ch writes
// the retry budget, wheel size and minimum reply length; it is always ready and
// is meant to be written while the block is idle.
// Timing: a query or reply reads the store when accepted and presents its result
// through the output register (a query that evicts an entry presents the evicted
// item, then the forwarded item). A tick walks the whole table, one entry a cycle
// through the store's read port unless a hit waits for the output register. One
// item is in work at a time; req_ch.ready is high only between items.
// Results leave through a single output register; a tick holds each hit back in a
// pending register so that the last flag is known. When rsp_ch stalls, the scan
// halts at a hit while an item is held and resumes when the register drains.
// Reset clears the valid bits, counters, wheel position and relay ID counter
// and loads the default register values; no clearing pass is needed.
`default_nettype none

module transaction_id_remap_table (
   input  logic         clock,
   input  logic         reset,
   trt_req_if.sink      req_ch,
   trt_rsp_if.source    rsp_ch,
   trt_csr_if.sink      csr_ch
);

   localparam logic [trt_pkg::IDX_W-1:0] LAST_IDX = trt_pkg::IDX_W'(trt_pkg::TABLE_DEPTH - 1);

   trt_pkg::state_type               state_ff, state_in;
   trt_pkg::op_type                  op_ff, op_in;
   logic [trt_pkg::ID_W-1:0]         id_ff, id_in;
   logic [trt_pkg::ID_W-1:0]         tag_ff, tag_in;
   logic [trt_pkg::LEN_W-1:0]        len_ff, len_in;

   logic [trt_pkg::RETX_W-1:0]       retx_ff, retx_in;
   logic [trt_pkg::TMO_W-1:0]        tmo_ff, tmo_in;
   logic [trt_pkg::LEN_W-1:0]        minlen_ff, minlen_in;

   logic [trt_pkg::ID_W-1:0]         relay_ff, relay_in;
   logic [trt_pkg::SLOT_W-1:0]       slot_ff, slot_in;
   logic [trt_pkg::ACT_W-1:0]        active_ff, active_in;
   logic [trt_pkg::CNT_W-1:0]        expired_ff, expired_in;
   logic [trt_pkg::CNT_W-1:0]        late_ff, late_in;
   logic [trt_pkg::CNT_W-1:0]        coll_ff, coll_in;
   logic [trt_pkg::IDX_W-1:0]        scan_ff, scan_in;

   trt_pkg::rsp_type                 pend_ff, pend_in;
   logic                             pend_valid_ff, pend_valid_in;
   trt_pkg::rsp_type                 rsp_ff, rsp_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   trt_pkg::tbl_ctl_type             ctl;
   trt_pkg::tbl_rd_type              rd;

   logic                             out_free;
   logic                             rsp_load;
   trt_pkg::rsp_type                 rsp_new;
   logic                             do_fwd;
   logic                             hit;
   logic [trt_pkg::TMO_W-1:0]        wheel;
   logic [trt_pkg::TMO_W-1:0]        slot_next;

   trt_table u_table (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .rd    (rd)
   );

   // wheel size clamped to the supported range
   always_comb begin
      if (tmo_ff < trt_pkg::WHEEL_MIN) begin
         wheel = trt_pkg::WHEEL_MIN;
      end else if (tmo_ff > trt_pkg::WHEEL_MAX) begin
         wheel = trt_pkg::WHEEL_MAX;
      end else begin
         wheel = tmo_ff;
      end
      slot_next = {1'b0, slot_ff} + 4'd1;
      if (slot_next >= wheel) begin
         slot_next = '0;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign hit      = rd.valid && (rd.entry.slot == slot_ff);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      tag_in        = tag_ff;
      len_in        = len_ff;
      relay_in      = relay_ff;
      slot_in       = slot_ff;
      active_in     = active_ff;
      expired_in    = expired_ff;
      late_in       = late_ff;
      coll_in       = coll_ff;
      scan_in       = scan_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      ctl           = '0;
      rsp_load      = 1'b0;
      rsp_new       = rsp_ff;
      do_fwd        = 1'b0;

      req_ch.ready = (state_ff == trt_pkg::ST_IDLE);

      case (state_ff)
         trt_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               op_in  = trt_pkg::op_type'(req_ch.operation);
               id_in  = req_ch.txn_id;
               tag_in = req_ch.client_tag;
               len_in = req_ch.msg_length;
               case (trt_pkg::op_type'(req_ch.operation))
                  trt_pkg::OP_QUERY: begin
                     ctl.rd_en   = 1'b1;
                     ctl.rd_addr = relay_ff[trt_pkg::IDX_W-1:0];
                     state_in    = trt_pkg::ST_LOOKUP;
                  end
                  trt_pkg::OP_REPLY: begin
                     ctl.rd_en   = 1'b1;
                     ctl.rd_addr = req_ch.txn_id[trt_pkg::IDX_W-1:0];
                     state_in    = trt_pkg::ST_LOOKUP;
                  end
                  trt_pkg::OP_TICK: begin
                     slot_in       = slot_next[trt_pkg::SLOT_W-1:0];
                     ctl.rd_en     = 1'b1;
                     ctl.rd_addr   = '0;
                     scan_in       = '0;
                     pend_valid_in = 1'b0;
                     state_in      = trt_pkg::ST_SCAN;
                  end
                  default: begin
                     state_in = trt_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         trt_pkg::ST_LOOKUP: begin
            if (out_free) begin
               case (op_ff)
                  trt_pkg::OP_QUERY: begin
                     if (rd.valid) begin
                        // old occupant leaves first; ST_FWD then writes the new entry
                        active_in = active_ff - 7'd1;
                        coll_in   = coll_ff + 32'd1;
                        rsp_new   = '{trt_pkg::KIND_EVICTED, rd.entry.relay_id,
                                      rd.entry.orig_id, rd.entry.client_tag,
                                      active_ff - 7'd1, expired_ff, late_ff,
                                      coll_ff + 32'd1, 1'b0};
                        rsp_load  = 1'b1;
                        state_in  = trt_pkg::ST_FWD;
                     end else begin
                        do_fwd = 1'b1;
                     end
                  end
                  trt_pkg::OP_REPLY: begin
                     rsp_load = 1'b1;
                     state_in = trt_pkg::ST_IDLE;
                     if (len_ff < minlen_ff) begin
                        rsp_new = '{trt_pkg::KIND_SHORT, id_ff, '0, '0, active_ff,
                                    expired_ff, late_ff, coll_ff, 1'b1};
                     end else if (rd.valid && rd.entry.relay_id == id_ff) begin
                        ctl.vld_en   = 1'b1;
                        ctl.wr_addr  = id_ff[trt_pkg::IDX_W-1:0];
                        ctl.wr_valid = 1'b0;
                        active_in    = active_ff - 7'd1;
                        rsp_new      = '{trt_pkg::KIND_MATCHED, id_ff, rd.entry.orig_id,
                                         rd.entry.client_tag, active_ff - 7'd1,
                                         expired_ff, late_ff, coll_ff, 1'b1};
                     end else begin
                        late_in = late_ff + 32'd1;
                        rsp_new = '{trt_pkg::KIND_ORPHANED, id_ff, '0, '0, active_ff,
                                    expired_ff, late_ff + 32'd1, coll_ff, 1'b1};
                     end
                  end
                  default: begin
                     state_in = trt_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         trt_pkg::ST_FWD: begin
            if (out_free) begin
               do_fwd = 1'b1;
            end
         end

         trt_pkg::ST_SCAN: begin
            // a hit with an item already held waits for the output register
            if (!(hit && pend_valid_ff && !out_free)) begin
               if (hit) begin
                  if (pend_valid_ff) begin
                     rsp_new  = pend_ff;
                     rsp_load = 1'b1;
                  end
                  pend_valid_in = 1'b1;
                  ctl.wr_addr   = scan_ff;
                  if (rd.entry.retries != '0) begin
                     ctl.wr_en            = 1'b1;
                     ctl.wr_valid         = 1'b1;
                     ctl.wr_data          = rd.entry;
                     ctl.wr_data.retries  = rd.entry.retries - 3'd1;
                     pend_in = '{trt_pkg::KIND_RESEND, rd.entry.relay_id,
                                 rd.entry.orig_id, rd.entry.client_tag, active_ff,
                                 expired_ff, late_ff, coll_ff, 1'b0};
                  end else begin
                     ctl.vld_en   = 1'b1;
                     ctl.wr_valid = 1'b0;
                     active_in    = active_ff - 7'd1;
                     expired_in   = expired_ff + 32'd1;
                     pend_in = '{trt_pkg::KIND_EXPIRED, rd.entry.relay_id,
                                 rd.entry.orig_id, rd.entry.client_tag, active_ff - 7'd1,
                                 expired_ff + 32'd1, late_ff, coll_ff, 1'b0};
                  end
               end
               if (scan_ff == LAST_IDX) begin
                  state_in = trt_pkg::ST_SCAN_END;
               end else begin
                  scan_in     = scan_ff + 1'b1;
                  ctl.rd_en   = 1'b1;
                  ctl.rd_addr = scan_ff + 1'b1;
               end
            end
         end

         trt_pkg::ST_SCAN_END: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = trt_pkg::ST_IDLE;
               if (pend_valid_ff) begin
                  rsp_new      = pend_ff;
                  rsp_new.last = 1'b1;
               end else begin
                  rsp_new = '{trt_pkg::KIND_IDLE, '0, '0, '0, active_ff, expired_ff,
                              late_ff, coll_ff, 1'b1};
               end
               pend_valid_in = 1'b0;
            end
         end

         default: begin
            state_in = trt_pkg::ST_IDLE;
         end
      endcase

      if (do_fwd) begin
         ctl.wr_en            = 1'b1;
         ctl.wr_valid         = 1'b1;
         ctl.wr_addr          = relay_ff[trt_pkg::IDX_W-1:0];
         ctl.wr_data.relay_id   = relay_ff;
         ctl.wr_data.orig_id    = id_ff;
         ctl.wr_data.client_tag = tag_ff;
         ctl.wr_data.retries    = retx_ff;
         ctl.wr_data.slot       = slot_ff;
         active_in = active_ff + 7'd1;
         relay_in  = relay_ff + 16'd1;
         rsp_new   = '{trt_pkg::KIND_FORWARDED, relay_ff, id_ff, tag_ff, active_ff + 7'd1,
                       expired_ff, late_ff, coll_ff, 1'b1};
         rsp_load  = 1'b1;
         state_in  = trt_pkg::ST_IDLE;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_in       = rsp_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = rsp_new;
      end
   end

   // configuration writes
   assign csr_ch.ready = 1'b1;

   always_comb begin
      retx_in   = retx_ff;
      tmo_in    = tmo_ff;
      minlen_in = minlen_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            trt_pkg::CSR_RETX:   retx_in   = csr_ch.data[trt_pkg::RETX_W-1:0];
            trt_pkg::CSR_TMO:    tmo_in    = csr_ch.data[trt_pkg::TMO_W-1:0];
            trt_pkg::CSR_MINLEN: minlen_in = csr_ch.data;
            default: begin
               retx_in = retx_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= trt_pkg::ST_IDLE;
         retx_ff       <= trt_pkg::RETX_RESET;
         tmo_ff        <= trt_pkg::TMO_RESET;
         minlen_ff     <= trt_pkg::MINLEN_RESET;
         relay_ff      <= '0;
         slot_ff       <= '0;
         active_ff     <= '0;
         expired_ff    <= '0;
         late_ff       <= '0;
         coll_ff       <= '0;
         scan_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         retx_ff       <= retx_in;
         tmo_ff        <= tmo_in;
         minlen_ff     <= minlen_in;
         relay_ff      <= relay_in;
         slot_ff       <= slot_in;
         active_ff     <= active_in;
         expired_ff    <= expired_in;
         late_ff       <= late_in;
         coll_ff       <= coll_in;
         scan_ff       <= scan_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      id_ff   <= id_in;
      tag_ff  <= tag_in;
      len_ff  <= len_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.kind            = rsp_ff.kind;
   assign rsp_ch.relay_id        = rsp_ff.relay_id;
   assign rsp_ch.orig_id         = rsp_ff.orig_id;
   assign rsp_ch.client_tag_out  = rsp_ff.client_tag;
   assign rsp_ch.active_total    = rsp_ff.active_total;
   assign rsp_ch.expired_total   = rsp_ff.expired_total;
   assign rsp_ch.late_total      = rsp_ff.late_total;
   assign rsp_ch.collision_total = rsp_ff.collision_total;
   assign rsp_ch.last            = rsp_ff.last;

endmodule

`default_nettype wire

// File: rtl/trt_table.sv
// Entry store: synchronous single-read single-write memory plus valid flops.
// Depends on trt_pkg (entry and control structs).
`default_nettype none

module trt_table (
   input  logic                 clock,
   input  logic                 reset,
   input  trt_pkg::tbl_ctl_type ctl,
   output trt_pkg::tbl_rd_type  rd
);

   trt_pkg::entry_type                mem_q [trt_pkg::TABLE_DEPTH];
   logic [trt_pkg::TABLE_DEPTH-1:0]   valid_ff;
   trt_pkg::tbl_rd_type               rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_q[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_ff.entry <= mem_q[ctl.rd_addr];
         rd_ff.valid <= valid_ff[ctl.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.wr_en || ctl.vld_en) begin
         valid_ff[ctl.wr_addr] <= ctl.wr_valid;
      end
   end

   assign rd = rd_ff;

endmodule

`default_nettype wire
